@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is low
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked check, active during reset too
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ sv/bmp_pkg.sv @@
// ----------------------------------------------------------------------------
// bmp_pkg
// Widths, codes, state type and unit structs of the prime field BM block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bmp_pkg;

    localparam int MAX_LEN = 1024;
    localparam int W       = 31;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int PA_W    = $clog2(MAX_LEN + 1);
    localparam int SA_W    = $clog2(MAX_LEN);
    localparam int STEP_W  = $clog2(W + 1);

    localparam logic [W-1:0] MOD_RESET = {W{1'b1}};

    typedef enum logic [1:0] {
        KIND_PUSH  = 2'd0,
        KIND_READ  = 2'd1,
        KIND_CLEAR = 2'd2
    } t_kind;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_RED,
        ST_DOT_CHK,
        ST_DOT_RD,
        ST_DOT_RC,
        ST_DOT_MUL,
        ST_DISC,
        ST_INV_BASE,
        ST_INV_CHK,
        ST_INV_R,
        ST_INV_SQ,
        ST_SCALE,
        ST_SAVE_RD,
        ST_SAVE_WR,
        ST_COR_CHK,
        ST_COR_RD,
        ST_COR_M,
        ST_COR_C,
        ST_HLP_RD,
        ST_HLP_WR,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic         start;
        logic [W-1:0] a;
        logic [W-1:0] b;
        logic [W-1:0] p;
    } t_mm_req;

    typedef struct packed {
        logic         busy;
        logic         done;
        logic [W-1:0] res;
    } t_mm_rsp;

endpackage

@@ sv/bmp_ifs.sv @@
// ----------------------------------------------------------------------------
// bmp channel interfaces
// Item, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bmp_item_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               kind;
    logic [bmp_pkg::W-1:0]    element;
    logic [10:0]              coeff_index;

    modport source (output valid, kind, element, coeff_index, input ready);
    modport sink   (input valid, kind, element, coeff_index, output ready);
endinterface

interface bmp_result_if;
    logic                        valid;
    logic                        ready;
    logic [bmp_pkg::LEN_W-1:0]   poly_length;
    logic [bmp_pkg::W-1:0]       discrepancy;
    logic [bmp_pkg::W-1:0]       coefficient;
    logic                        error;

    modport source (output valid, poly_length, discrepancy, coefficient, error,
                    input ready);
    modport sink   (input valid, poly_length, discrepancy, coefficient, error,
                    output ready);
endinterface

interface bmp_cfg_if;
    logic                  valid;
    logic                  ready;
    logic [bmp_pkg::W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

@@ sv/bmp_mulmod.sv @@
// ----------------------------------------------------------------------------
// bmp_mulmod
// Bit-serial modular multiplier: a * b mod p, one bit of b per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmp_mulmod (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bmp_pkg::t_mm_req i_req,
    output bmp_pkg::t_mm_rsp o_rsp
);

    logic                       r_busy, n_busy;
    logic                       r_done, n_done;
    logic [bmp_pkg::STEP_W-1:0] r_cnt, n_cnt;
    logic [bmp_pkg::W-1:0]      r_acc, n_acc;
    logic [bmp_pkg::W-1:0]      r_a, n_a;
    logic [bmp_pkg::W-1:0]      r_b, n_b;
    logic [bmp_pkg::W-1:0]      r_p, n_p;
    logic [bmp_pkg::W:0]        c_dbl, c_dbl_red, c_sum, c_sum_red;

    always_comb begin
        c_dbl     = {r_acc, 1'b0};
        c_dbl_red = (c_dbl >= {1'b0, r_p}) ? c_dbl - {1'b0, r_p} : c_dbl;
        c_sum     = c_dbl_red + (r_b[bmp_pkg::W-1] ? {1'b0, r_a} : '0);
        c_sum_red = (c_sum >= {1'b0, r_p}) ? c_sum - {1'b0, r_p} : c_sum;
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_a    = r_a;
        n_b    = r_b;
        n_p    = r_p;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_acc  = '0;
            n_a    = i_req.a;
            n_b    = i_req.b;
            n_p    = i_req.p;
        end else if (r_busy) begin
            n_acc = c_sum_red[bmp_pkg::W-1:0];
            n_b   = {r_b[bmp_pkg::W-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == bmp_pkg::STEP_W'(bmp_pkg::W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
        r_p   <= n_p;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_acc;

endmodule

@@ sv/berlekamp_massey_prime_field.sv @@
// ----------------------------------------------------------------------------
// berlekamp_massey_prime_field
// Berlekamp-Massey over GF(p) with polynomial memories and a shared
// bit-serial modular multiplier under a sequencer.
// ----------------------------------------------------------------------------
// channel    dir  fields
// i_item     in   kind, element, coeff_index
// o_result   out  poly_length, discrepancy, coefficient, error
// i_cfg      in   data (modulus), always ready
//
// Each product or reduction uses the shared multiplier. A push reduces the
// element, forms the discrepancy as a dot product and, if nonzero, takes a
// Fermat inverse (base, a square per exponent bit, one more product per set
// bit, scale), walks the correction with two products per nonzero helper
// coefficient and on a length change copies C to T and B from T. Reset and
// clear sweep all 1025 entries; i_item is not ready while an item is at work.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module berlekamp_massey_prime_field (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bmp_item_if.sink     i_item,
    bmp_result_if.source o_result,
    bmp_cfg_if.sink      i_cfg
);

    localparam int W     = bmp_pkg::W;
    localparam int LEN_W = bmp_pkg::LEN_W;
    localparam int PA_W  = bmp_pkg::PA_W;
    localparam int SA_W  = bmp_pkg::SA_W;
    localparam int ST_W  = bmp_pkg::STEP_W;

    bmp_pkg::t_state r_state, n_state;

    logic [W-1:0]     r_mod;
    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_gap, n_gap;
    logic [W-1:0]     r_ldisc, n_ldisc;
    logic [LEN_W-1:0] r_cnt, n_cnt;
    logic [LEN_W-1:0] r_i, n_i;
    logic [LEN_W-1:0] r_j, n_j;
    logic [LEN_W-1:0] r_oldlen, n_oldlen;
    logic             r_branch, n_branch;
    logic             r_clrrsp, n_clrrsp;
    logic [W-1:0]     r_acc, n_acc;
    logic [W-1:0]     r_sq, n_sq;
    logic [W-1:0]     r_cv, n_cv;
    logic [W-1:0]     r_prod, n_prod;
    logic [W-1:0]     r_base, n_base;
    logic [W-1:0]     r_inv, n_inv;
    logic [W-1:0]     r_e, n_e;
    logic [ST_W-1:0]  r_ebit, n_ebit;
    logic [W-1:0]     r_scale, n_scale;
    logic [W-1:0]     r_rdisc, n_rdisc;
    logic [W-1:0]     r_rcoef, n_rcoef;
    logic             r_rerr, n_rerr;
    logic             r_ovalid, n_ovalid;
    logic [LEN_W-1:0] r_olen;
    logic [W-1:0]     r_odisc, r_ocoef;
    logic             r_oerr;

    logic [W-1:0] c_mem [0:bmp_pkg::MAX_LEN];
    logic [W-1:0] b_mem [0:bmp_pkg::MAX_LEN];
    logic [W-1:0] t_mem [0:bmp_pkg::MAX_LEN];
    logic [W-1:0] s_mem [0:bmp_pkg::MAX_LEN-1];
    logic [W-1:0] r_c_rd, r_b_rd, r_t_rd, r_s_rd;

    logic            c_we, b_we, t_we, s_we;
    logic [PA_W-1:0] c_wa, c_ra, b_wa, b_ra, t_wa, t_ra;
    logic [SA_W-1:0] s_wa, s_ra;
    logic [W-1:0]    c_wd, b_wd, t_wd, s_wd;

    bmp_pkg::t_mm_req mm_req;
    bmp_pkg::t_mm_rsp mm_rsp;

    logic             item_acc, out_free, dot_go, grow, last_j;
    logic [W-1:0]     p_eff;
    logic [LEN_W:0]   cidx;
    logic [LEN_W-1:0] dot_off;
    logic [W:0]       add_s, sub_s;

    bmp_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mm_req),
        .o_rsp   (mm_rsp)
    );

    assign i_item.ready = (r_state == bmp_pkg::ST_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign item_acc     = i_item.valid && i_item.ready;
    assign out_free     = !r_ovalid || o_result.ready;

    assign p_eff   = (r_mod < W'(2)) ? W'(2) : r_mod;
    assign dot_go  = (r_j <= r_len) && (r_j <= r_i);
    assign dot_off = r_i - r_j;
    assign grow    = ({1'b0, r_len} << 1) <= {1'b0, r_i};
    assign cidx    = {1'b0, r_j} + {1'b0, r_gap};
    assign last_j  = (r_j == LEN_W'(bmp_pkg::MAX_LEN));

    always_comb begin
        add_s = {1'b0, r_acc} + {1'b0, mm_rsp.res};
        if (add_s >= {1'b0, p_eff}) begin
            add_s = add_s - {1'b0, p_eff};
        end
        if (mm_rsp.res >= r_prod) begin
            sub_s = {1'b0, mm_rsp.res} - {1'b0, r_prod};
        end else begin
            sub_s = {1'b0, mm_rsp.res} + {1'b0, p_eff} - {1'b0, r_prod};
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bmp_pkg::ST_CLEAR: begin
                if (last_j) n_state = r_clrrsp ? bmp_pkg::ST_DONE : bmp_pkg::ST_IDLE;
            end
            bmp_pkg::ST_IDLE: begin
                if (item_acc) begin
                    case (bmp_pkg::t_kind'(i_item.kind))
                        bmp_pkg::KIND_PUSH:
                            n_state = (r_cnt >= LEN_W'(bmp_pkg::MAX_LEN)) ?
                                      bmp_pkg::ST_DONE : bmp_pkg::ST_RED;
                        bmp_pkg::KIND_READ:
                            n_state = (i_item.coeff_index > 11'(bmp_pkg::MAX_LEN)) ?
                                      bmp_pkg::ST_DONE : bmp_pkg::ST_READ;
                        bmp_pkg::KIND_CLEAR: n_state = bmp_pkg::ST_CLEAR;
                        default:             n_state = bmp_pkg::ST_DONE;
                    endcase
                end
            end
            bmp_pkg::ST_READ:    n_state = bmp_pkg::ST_DONE;
            bmp_pkg::ST_RED:     if (mm_rsp.done) n_state = bmp_pkg::ST_DOT_CHK;
            bmp_pkg::ST_DOT_CHK: n_state = dot_go ? bmp_pkg::ST_DOT_RD : bmp_pkg::ST_DISC;
            bmp_pkg::ST_DOT_RD:  n_state = bmp_pkg::ST_DOT_RC;
            bmp_pkg::ST_DOT_RC:  if (mm_rsp.done) n_state = bmp_pkg::ST_DOT_MUL;
            bmp_pkg::ST_DOT_MUL: if (mm_rsp.done) n_state = bmp_pkg::ST_DOT_CHK;
            bmp_pkg::ST_DISC:
                n_state = (r_acc == '0) ? bmp_pkg::ST_DONE : bmp_pkg::ST_INV_BASE;
            bmp_pkg::ST_INV_BASE: if (mm_rsp.done) n_state = bmp_pkg::ST_INV_CHK;
            bmp_pkg::ST_INV_CHK: begin
                if (r_ebit == ST_W'(W)) n_state = bmp_pkg::ST_SCALE;
                else if (r_e[0])        n_state = bmp_pkg::ST_INV_R;
                else                    n_state = bmp_pkg::ST_INV_SQ;
            end
            bmp_pkg::ST_INV_R:  if (mm_rsp.done) n_state = bmp_pkg::ST_INV_SQ;
            bmp_pkg::ST_INV_SQ: if (mm_rsp.done) n_state = bmp_pkg::ST_INV_CHK;
            bmp_pkg::ST_SCALE: begin
                if (mm_rsp.done) n_state = grow ? bmp_pkg::ST_SAVE_RD : bmp_pkg::ST_COR_CHK;
            end
            bmp_pkg::ST_SAVE_RD: n_state = bmp_pkg::ST_SAVE_WR;
            bmp_pkg::ST_SAVE_WR:
                n_state = (r_j == r_oldlen) ? bmp_pkg::ST_COR_CHK : bmp_pkg::ST_SAVE_RD;
            bmp_pkg::ST_COR_CHK: begin
                if (cidx <= (LEN_W+1)'(bmp_pkg::MAX_LEN)) n_state = bmp_pkg::ST_COR_RD;
                else n_state = r_branch ? bmp_pkg::ST_HLP_RD : bmp_pkg::ST_DONE;
            end
            bmp_pkg::ST_COR_RD:
                n_state = (r_b_rd == '0) ? bmp_pkg::ST_COR_CHK : bmp_pkg::ST_COR_M;
            bmp_pkg::ST_COR_M:  if (mm_rsp.done) n_state = bmp_pkg::ST_COR_C;
            bmp_pkg::ST_COR_C:  if (mm_rsp.done) n_state = bmp_pkg::ST_COR_CHK;
            bmp_pkg::ST_HLP_RD: n_state = bmp_pkg::ST_HLP_WR;
            bmp_pkg::ST_HLP_WR: if (last_j) n_state = bmp_pkg::ST_DONE;
                                else n_state = bmp_pkg::ST_HLP_RD;
            bmp_pkg::ST_DONE:   if (out_free) n_state = bmp_pkg::ST_IDLE;
            default:            n_state = bmp_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_len = r_len;   n_gap = r_gap;   n_ldisc = r_ldisc; n_cnt = r_cnt;
        n_i = r_i;       n_j = r_j;       n_oldlen = r_oldlen;
        n_branch = r_branch; n_clrrsp = r_clrrsp;
        n_acc = r_acc;   n_sq = r_sq;     n_cv = r_cv;       n_prod = r_prod;
        n_base = r_base; n_inv = r_inv;   n_e = r_e;         n_ebit = r_ebit;
        n_scale = r_scale;
        n_rdisc = r_rdisc; n_rcoef = r_rcoef; n_rerr = r_rerr;
        n_ovalid = r_ovalid && !o_result.ready;
        c_we = 1'b0; c_wa = '0; c_wd = '0; c_ra = '0;
        b_we = 1'b0; b_wa = '0; b_wd = '0; b_ra = '0;
        t_we = 1'b0; t_wa = '0; t_wd = '0; t_ra = '0;
        s_we = 1'b0; s_wa = '0; s_wd = '0; s_ra = '0;
        mm_req.start = 1'b0;
        mm_req.a     = W'(1);
        mm_req.b     = '0;
        mm_req.p     = p_eff;
        case (r_state)
            bmp_pkg::ST_CLEAR: begin
                c_we = 1'b1; c_wa = r_j[PA_W-1:0];
                b_we = 1'b1; b_wa = r_j[PA_W-1:0];
                c_wd = (r_j == '0) ? W'(1) : '0;
                b_wd = c_wd;
                n_j  = last_j ? '0 : r_j + 1'b1;
            end
            bmp_pkg::ST_IDLE: begin
                if (item_acc) begin
                    n_rdisc = '0; n_rcoef = '0; n_rerr = 1'b0;
                    case (bmp_pkg::t_kind'(i_item.kind))
                        bmp_pkg::KIND_PUSH: begin
                            if (r_cnt >= LEN_W'(bmp_pkg::MAX_LEN)) begin
                                n_rerr = 1'b1;
                            end else begin
                                n_i          = r_cnt;
                                mm_req.start = 1'b1;
                                mm_req.b     = i_item.element;
                            end
                        end
                        bmp_pkg::KIND_READ: begin
                            if (i_item.coeff_index > 11'(bmp_pkg::MAX_LEN)) n_rerr = 1'b1;
                            else c_ra = i_item.coeff_index[PA_W-1:0];
                        end
                        bmp_pkg::KIND_CLEAR: begin
                            n_len = '0; n_gap = LEN_W'(1); n_ldisc = W'(1);
                            n_cnt = '0; n_j = '0; n_clrrsp = 1'b1;
                        end
                        default: n_rerr = 1'b0;
                    endcase
                end
            end
            bmp_pkg::ST_READ: n_rcoef = r_c_rd;
            bmp_pkg::ST_RED: begin
                if (mm_rsp.done) begin
                    n_acc = mm_rsp.res;
                    s_we  = 1'b1; s_wa = r_i[SA_W-1:0]; s_wd = mm_rsp.res;
                    n_j   = LEN_W'(1);
                end
            end
            bmp_pkg::ST_DOT_CHK: begin
                if (dot_go) begin
                    c_ra = r_j[PA_W-1:0];
                    s_ra = dot_off[SA_W-1:0];
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            bmp_pkg::ST_DOT_RD: begin
                mm_req.start = 1'b1;
                mm_req.b     = r_c_rd;
                n_sq         = r_s_rd;
            end
            bmp_pkg::ST_DOT_RC: begin
                if (mm_rsp.done) begin
                    mm_req.start = 1'b1;
                    mm_req.a     = mm_rsp.res;
                    mm_req.b     = r_sq;
                end
            end
            bmp_pkg::ST_DOT_MUL: begin
                if (mm_rsp.done) begin
                    n_acc = add_s[W-1:0];
                    n_j   = r_j + 1'b1;
                end
            end
            bmp_pkg::ST_DISC: begin
                if (r_acc == '0) begin
                    n_gap = r_gap + 1'b1;
                end else begin
                    mm_req.start = 1'b1;
                    mm_req.b     = r_ldisc;
                end
            end
            bmp_pkg::ST_INV_BASE: begin
                if (mm_rsp.done) begin
                    n_base = mm_rsp.res;
                    n_inv  = W'(1);
                    n_e    = p_eff - W'(2);
                    n_ebit = '0;
                end
            end
            bmp_pkg::ST_INV_CHK: begin
                mm_req.start = 1'b1;
                if (r_ebit == ST_W'(W)) begin
                    mm_req.a = r_acc;  mm_req.b = r_inv;
                end else if (r_e[0]) begin
                    mm_req.a = r_base; mm_req.b = r_inv;
                end else begin
                    mm_req.a = r_base; mm_req.b = r_base;
                end
            end
            bmp_pkg::ST_INV_R: begin
                if (mm_rsp.done) begin
                    n_inv        = mm_rsp.res;
                    mm_req.start = 1'b1;
                    mm_req.a     = r_base;
                    mm_req.b     = r_base;
                end
            end
            bmp_pkg::ST_INV_SQ: begin
                if (mm_rsp.done) begin
                    n_base = mm_rsp.res;
                    n_e    = r_e >> 1;
                    n_ebit = r_ebit + 1'b1;
                end
            end
            bmp_pkg::ST_SCALE: begin
                if (mm_rsp.done) begin
                    n_scale  = mm_rsp.res;
                    n_branch = grow;
                    n_oldlen = r_len;
                    n_j      = '0;
                end
            end
            bmp_pkg::ST_SAVE_RD: c_ra = r_j[PA_W-1:0];
            bmp_pkg::ST_SAVE_WR: begin
                t_we = 1'b1; t_wa = r_j[PA_W-1:0]; t_wd = r_c_rd;
                n_j  = (r_j == r_oldlen) ? '0 : r_j + 1'b1;
            end
            bmp_pkg::ST_COR_CHK: begin
                if (cidx <= (LEN_W+1)'(bmp_pkg::MAX_LEN)) begin
                    b_ra = r_j[PA_W-1:0];
                    c_ra = cidx[PA_W-1:0];
                end else begin
                    n_j = '0;
                    if (!r_branch) begin
                        n_gap   = r_gap + 1'b1;
                        n_rdisc = r_acc;
                    end
                end
            end
            bmp_pkg::ST_COR_RD: begin
                if (r_b_rd == '0) begin
                    n_j = r_j + 1'b1;
                end else begin
                    mm_req.start = 1'b1;
                    mm_req.a     = r_scale;
                    mm_req.b     = r_b_rd;
                    n_cv         = r_c_rd;
                end
            end
            bmp_pkg::ST_COR_M: begin
                if (mm_rsp.done) begin
                    n_prod       = mm_rsp.res;
                    mm_req.start = 1'b1;
                    mm_req.b     = r_cv;
                end
            end
            bmp_pkg::ST_COR_C: begin
                if (mm_rsp.done) begin
                    c_we = 1'b1; c_wa = cidx[PA_W-1:0]; c_wd = sub_s[W-1:0];
                    n_j  = r_j + 1'b1;
                end
            end
            bmp_pkg::ST_HLP_RD: t_ra = r_j[PA_W-1:0];
            bmp_pkg::ST_HLP_WR: begin
                b_we = 1'b1; b_wa = r_j[PA_W-1:0];
                b_wd = (r_j <= r_oldlen) ? r_t_rd : '0;
                if (last_j) begin
                    n_len   = r_i + 1'b1 - r_oldlen;
                    n_ldisc = r_acc;
                    n_gap   = LEN_W'(1);
                    n_rdisc = r_acc;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            bmp_pkg::ST_DONE: if (out_free) n_ovalid = 1'b1;
            default: n_j = r_j;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bmp_pkg::ST_CLEAR;
            r_mod    <= bmp_pkg::MOD_RESET;
            r_len    <= '0;
            r_gap    <= LEN_W'(1);
            r_ldisc  <= W'(1);
            r_cnt    <= '0;
            r_j      <= '0;
            r_clrrsp <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            if (i_cfg.valid && i_cfg.ready) r_mod <= i_cfg.data;
            r_len    <= n_len;
            r_gap    <= n_gap;
            r_ldisc  <= n_ldisc;
            r_cnt    <= n_cnt;
            r_j      <= n_j;
            r_clrrsp <= n_clrrsp;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_oldlen <= n_oldlen;
        r_branch <= n_branch;
        r_acc    <= n_acc;
        r_sq     <= n_sq;
        r_cv     <= n_cv;
        r_prod   <= n_prod;
        r_base   <= n_base;
        r_inv    <= n_inv;
        r_e      <= n_e;
        r_ebit   <= n_ebit;
        r_scale  <= n_scale;
        r_rdisc  <= n_rdisc;
        r_rcoef  <= n_rcoef;
        r_rerr   <= n_rerr;
        if (r_state == bmp_pkg::ST_DONE && out_free) begin
            r_olen  <= r_len;
            r_odisc <= r_rdisc;
            r_ocoef <= r_rcoef;
            r_oerr  <= r_rerr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_we) c_mem[c_wa] <= c_wd;
        r_c_rd <= c_mem[c_ra];
    end

    always_ff @(posedge i_clk) begin
        if (b_we) b_mem[b_wa] <= b_wd;
        r_b_rd <= b_mem[b_ra];
    end

    always_ff @(posedge i_clk) begin
        if (t_we) t_mem[t_wa] <= t_wd;
        r_t_rd <= t_mem[t_ra];
    end

    always_ff @(posedge i_clk) begin
        if (s_we) s_mem[s_wa] <= s_wd;
        r_s_rd <= s_mem[s_ra];
    end

    assign o_result.valid       = r_ovalid;
    assign o_result.poly_length = r_olen;
    assign o_result.discrepancy = r_odisc;
    assign o_result.coefficient = r_ocoef;
    assign o_result.error       = r_oerr;

    `ASSERT_CLK(a_mm_no_restart, mm_req.start |-> !mm_rsp.busy,
                "multiplier started while busy")
    `ASSERT_CLK(a_done_loads_out,
                $past(r_state) == bmp_pkg::ST_DONE && r_state == bmp_pkg::ST_IDLE
                |-> r_ovalid, "item finished without a result")
    `ASSERT_CLK(a_len_bound, r_len <= r_cnt, "complexity exceeds pushed count")
    `ASSERT_ALWAYS(a_reset_clear, !i_rst_n |=> r_state == bmp_pkg::ST_CLEAR && !r_ovalid,
                   "reset does not start the clearing sweep")

endmodule
